// ===== hw/rtl/ikh_pkg.sv =====
// Shared constants, types and codes of the IP-keyed flow table.
package ikh_pkg;

  // Table geometry
  localparam int BucketBits  = 10;
  localparam int Ways        = 4;
  localparam int TunnelBits  = 16;
  localparam int NumBuckets  = 1 << BucketBits;
  localparam int NumSlots    = NumBuckets * Ways;
  localparam int WayW        = (Ways > 1) ? $clog2(Ways) : 1;

  // Field widths
  localparam int KeyW         = 32;
  localparam int TunnelFieldW = 16;
  localparam int TunW         = (TunnelBits < TunnelFieldW) ? TunnelBits : TunnelFieldW;
  localparam int EntryCountW  = 13;
  localparam int OverrideW    = 32;
  localparam int LiveW        = $clog2(NumSlots + 1);

  // Key scrambling and bucket reduction
  localparam int              ScrambleW      = 9;
  localparam logic [ScrambleW-1:0] KeyScramble = ScrambleW'(13 * 29);
  localparam logic [KeyW-1:0] HashPrimeReset = 32'd65521;
  localparam int              DivBitsPerStep = 2;
  localparam int              DivSteps       = KeyW / DivBitsPerStep;
  localparam int              DivCntW        = $clog2(DivSteps);

  // Request queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration port
  localparam int                   CfgAddrW     = 3;
  localparam int                   CfgDataW     = 32;
  localparam logic [CfgAddrW-3:0]  RegHashPrime = '0;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdSearch = 2'd1,
    CmdDelete = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StHit      = 2'd1,
    StMiss     = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TunW-1:0] tun;
  } slot_t;

  typedef slot_t [Ways-1:0] row_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [KeyW-1:0]       ip;
    logic [TunW-1:0]       tun;
    logic [BucketBits-1:0] bucket;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic [TunnelFieldW-1:0] tunnel;
    status_e                 status;
    logic [EntryCountW-1:0]  entries;
    logic [OverrideW-1:0]    overrides;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/ikh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ikh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ikh_front.sv =====
// Front end: takes requests, scrambles the key and reduces it to a bucket.
module ikh_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  output logic                            idle_o,
  input  logic [1:0]                      command_i,
  input  logic [ikh_pkg::KeyW-1:0]        ip_addr_i,
  input  logic [ikh_pkg::TunnelFieldW-1:0] tunnel_ref_i,
  input  logic [ikh_pkg::KeyW-1:0]        prime_i,
  input  ikh_pkg::q_stat_t                q_stat_i,
  output logic                            push_o,
  output ikh_pkg::req_t                   push_req_o
);

  localparam logic [1:0] FsIdle = 2'd0;
  localparam logic [1:0] FsMul  = 2'd1;
  localparam logic [1:0] FsDiv  = 2'd2;
  localparam logic [1:0] FsPush = 2'd3;

  localparam int KeyW = ikh_pkg::KeyW;
  localparam int ProdW = KeyW + ikh_pkg::ScrambleW;

  logic [1:0]                       state_q, state_d;
  logic [1:0]                       cmd_q;
  logic [KeyW-1:0]                  ip_q;
  logic [ikh_pkg::TunW-1:0]         tun_q;
  logic [KeyW-1:0]                  dvd_q, dvd_d;
  logic [KeyW-1:0]                  rem_q, rem_d;
  logic [ikh_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic [ProdW-1:0]                 scr_full;
  logic [KeyW:0]                    div_a, div_b, prime_x;
  logic [KeyW-1:0]                  rem_mid;

  assign scr_full = ip_q * ikh_pkg::KeyScramble;
  assign prime_x  = {1'b0, prime_i};

  // Two restoring remainder steps per cycle
  always_comb begin
    div_a   = {rem_q, dvd_q[KeyW-1]};
    if (div_a >= prime_x) begin
      div_a = div_a - prime_x;
    end
    rem_mid = div_a[KeyW-1:0];
    div_b   = {rem_mid, dvd_q[KeyW-2]};
    if (div_b >= prime_x) begin
      div_b = div_b - prime_x;
    end
  end

  // Sequence one request through scramble, reduce and hand-off
  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      FsIdle: begin
        if (accept_i) begin
          state_d = FsMul;
        end
      end
      FsMul: begin
        dvd_d = scr_full[KeyW-1:0];
        cnt_d = '0;
        if (prime_i == '0) begin
          rem_d   = scr_full[KeyW-1:0];
          state_d = FsPush;
        end else begin
          rem_d   = '0;
          state_d = FsDiv;
        end
      end
      FsDiv: begin
        rem_d = div_b[KeyW-1:0];
        dvd_d = {dvd_q[KeyW-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ikh_pkg::DivCntW'(ikh_pkg::DivSteps - 1)) begin
          state_d = FsPush;
        end
      end
      FsPush: begin
        push_o = 1'b1;
        if (!q_stat_i.full) begin
          state_d = FsIdle;
        end
      end
      default: begin
        state_d = FsIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request payload and the divider datapath
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q <= command_i;
      ip_q  <= ip_addr_i;
      tun_q <= ikh_pkg::TunW'(tunnel_ref_i);
    end
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign idle_o            = (state_q == FsIdle);
  assign push_req_o.cmd    = cmd_q;
  assign push_req_o.ip     = ip_q;
  assign push_req_o.tun    = tun_q;
  assign push_req_o.bucket = rem_q[ikh_pkg::BucketBits-1:0];

endmodule

// ===== hw/rtl/ikh_queue.sv =====
// Short request queue between the front end and the table engine.
module ikh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ikh_pkg::req_t    push_req_i,
  input  logic             pop_i,
  output ikh_pkg::req_t    head_o,
  output ikh_pkg::q_stat_t stat_o
);

  localparam int Depth = ikh_pkg::QueueDepth;

  ikh_pkg::req_t               mem_q [Depth];
  logic [ikh_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ikh_pkg::QCntW-1:0]   cnt_q;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == ikh_pkg::QCntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ikh_pkg::QPtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ikh_pkg::QPtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ===== hw/rtl/ikh_back.sv =====
// Table engine: clears the bucket RAM, then does one bucket read-modify-write per request.
module ikh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ikh_pkg::req_t    head_i,
  input  ikh_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ikh_pkg::rsp_t    rsp_o
);

  localparam logic [1:0] BsClear = 2'd0;
  localparam logic [1:0] BsIdle  = 2'd1;
  localparam logic [1:0] BsExec  = 2'd2;

  localparam int BucketBits = ikh_pkg::BucketBits;
  localparam int RowW       = $bits(ikh_pkg::row_t);

  logic [1:0]                      state_q, state_d;
  logic [BucketBits-1:0]           clr_q, clr_d;
  ikh_pkg::req_t                   cur_q;
  logic [ikh_pkg::LiveW-1:0]       live_q, live_d;
  logic [ikh_pkg::OverrideW-1:0]   ovr_q, ovr_d;
  logic                            out_valid_q;
  ikh_pkg::rsp_t                   rsp_q, rsp_d;
  logic                            fire;

  logic                            ram_we, ram_re;
  logic [BucketBits-1:0]           ram_waddr, ram_raddr;
  logic [RowW-1:0]                 ram_wdata, ram_rdata;
  ikh_pkg::row_t                   rd_row, new_row;

  logic                            hit, free;
  logic [ikh_pkg::WayW-1:0]        hit_idx, free_idx;

  ikh_ram #(
    .Width (RowW),
    .Depth (ikh_pkg::NumBuckets)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_row = ikh_pkg::row_t'(ram_rdata);
  assign fire   = (state_q == BsExec) && (!out_valid_q || !out_stall_i);

  // Find the first matching slot and the first free slot of the bucket
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int w = 0; w < ikh_pkg::Ways; w++) begin
      if (rd_row[w].valid) begin
        if (!hit && (rd_row[w].key == cur_q.ip)) begin
          hit     = 1'b1;
          hit_idx = ikh_pkg::WayW'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_idx = ikh_pkg::WayW'(w);
      end
    end
  end

  // Apply the command to the bucket and build the result
  always_comb begin
    new_row      = rd_row;
    live_d       = live_q;
    ovr_d        = ovr_q;
    rsp_d.found  = 1'b0;
    rsp_d.tunnel = '0;
    rsp_d.status = ikh_pkg::StMiss;
    unique case (cur_q.cmd)
      ikh_pkg::CmdInsert: begin
        if (hit) begin
          new_row[hit_idx].tun = cur_q.tun;
          ovr_d                = ovr_q + 1'b1;
          rsp_d.found          = 1'b1;
          rsp_d.tunnel         = ikh_pkg::TunnelFieldW'(cur_q.tun);
          rsp_d.status         = ikh_pkg::StHit;
        end else if (free) begin
          new_row[free_idx].valid = 1'b1;
          new_row[free_idx].key   = cur_q.ip;
          new_row[free_idx].tun   = cur_q.tun;
          live_d                  = live_q + 1'b1;
          rsp_d.tunnel            = ikh_pkg::TunnelFieldW'(cur_q.tun);
          rsp_d.status            = ikh_pkg::StInserted;
        end else begin
          rsp_d.status = ikh_pkg::StFull;
        end
      end
      ikh_pkg::CmdDelete: begin
        if (hit) begin
          new_row[hit_idx].valid = 1'b0;
          live_d                 = live_q - 1'b1;
          rsp_d.found            = 1'b1;
          rsp_d.tunnel           = ikh_pkg::TunnelFieldW'(rd_row[hit_idx].tun);
          rsp_d.status           = ikh_pkg::StHit;
        end
      end
      default: begin
        // search, and the unused code, which reads like a search
        if (hit) begin
          rsp_d.found  = 1'b1;
          rsp_d.tunnel = ikh_pkg::TunnelFieldW'(rd_row[hit_idx].tun);
          rsp_d.status = ikh_pkg::StHit;
        end
      end
    endcase
    rsp_d.entries   = ikh_pkg::EntryCountW'(live_d);
    rsp_d.overrides = ovr_d;
  end

  // Sequence clearing, bucket read and bucket write-back
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_q.bucket;
    ram_wdata = RowW'(new_row);
    ram_re    = 1'b0;
    ram_raddr = head_i.bucket;
    unique case (state_q)
      BsClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = BsIdle;
        end
      end
      BsIdle: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          state_d = BsExec;
        end
      end
      BsExec: begin
        if (fire) begin
          ram_we  = 1'b1;
          state_d = BsIdle;
        end
      end
      default: begin
        state_d = BsIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BsClear;
      clr_q       <= '0;
      live_q      <= '0;
      ovr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (fire) begin
        live_q      <= live_d;
        ovr_q       <= ovr_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the working request and the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign clearing_o  = (state_q == BsClear);
  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== hw/rtl/ip_keyed_hash_table.sv =====
// Top level of the IPv4-keyed flow table with APB configuration.
//
// Requests enter on in_valid_i / in_stall_o with a command (insert or
// update, search, delete), the IPv4 key and a tunnel reference. Each
// request yields one result on out_valid_o / out_stall_i: found flag,
// tunnel reference, status, live entry count and override count.
// The key is scrambled with one multiply, then reduced modulo hash_prime
// by a remainder unit that retires two bits per cycle and is skipped when
// hash_prime is zero; the front end takes no new request until it has
// handed the last one to the queue. The table engine then does one bucket
// RAM read and one write-back per request, and registers the result with
// the write-back. A two-entry queue lets the front end keep working while
// the engine waits on a stalled result; the result register holds its
// value while out_stall_i is high.
// After reset the engine clears all 1024 bucket rows, one per cycle, and
// in_stall_o stays high while they are cleared; hash_prime resets to 65521
// and may be written at any time the block is idle.
module ip_keyed_hash_table (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           command_i,
  input  logic [ikh_pkg::KeyW-1:0]             ip_addr_i,
  input  logic [ikh_pkg::TunnelFieldW-1:0]     tunnel_ref_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [ikh_pkg::TunnelFieldW-1:0]     tunnel_out_o,
  output logic [1:0]                           status_o,
  output logic [ikh_pkg::EntryCountW-1:0]      entry_count_o,
  output logic [ikh_pkg::OverrideW-1:0]        override_count_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ikh_pkg::CfgAddrW-1:0]         paddr,
  input  logic [ikh_pkg::CfgDataW-1:0]         pwdata,
  output logic [ikh_pkg::CfgDataW-1:0]         prdata,
  output logic                                 pready
);

  logic [ikh_pkg::KeyW-1:0] prime_q;
  logic                     front_idle, clearing, accept;
  logic                     push, pop;
  ikh_pkg::req_t            push_req, head;
  ikh_pkg::q_stat_t         q_stat;
  ikh_pkg::rsp_t            rsp;
  logic                     reg_sel;

  // Configuration register
  assign reg_sel = (paddr[ikh_pkg::CfgAddrW-1:2] == ikh_pkg::RegHashPrime);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? prime_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= ikh_pkg::HashPrimeReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      prime_q <= pwdata;
    end
  end

  // Request intake
  assign in_stall_o = !front_idle || clearing;
  assign accept     = in_valid_i && !in_stall_o;

  ikh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .idle_o       (front_idle),
    .command_i    (command_i),
    .ip_addr_i    (ip_addr_i),
    .tunnel_ref_i (tunnel_ref_i),
    .prime_i      (prime_q),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_req_o   (push_req)
  );

  ikh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  ikh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (rsp)
  );

  // Result fields
  assign found_o          = rsp.found;
  assign tunnel_out_o     = rsp.tunnel;
  assign status_o         = rsp.status;
  assign entry_count_o    = rsp.entries;
  assign override_count_o = rsp.overrides;

  // A miss or a full bucket reports no match and no tunnel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ikh_pkg::StMiss) || (status_o == ikh_pkg::StFull))
      |-> !found_o && (tunnel_out_o == '0))
    else $error("miss or full result carries a match");

  // Found is set exactly on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ikh_pkg::StHit) == found_o))
    else $error("found flag disagrees with status");

  // Live entries never exceed the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(entry_count_o) <= ikh_pkg::NumSlots))
    else $error("entry count beyond table size");

  // No request is accepted or popped from the queue while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !pop && !accept)
    else $error("request handled during clearing pass");

endmodule

// ===== tb/ip_keyed_hash_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the IPv4-keyed flow table: mirrored table, random traffic, APB.
module ip_keyed_hash_table_tb;
  import ikh_pkg::*;

  // Command code outside the enum; the block treats it as a search
  localparam logic [1:0] CmdSearchAlias = 2'd3;

  localparam logic [KeyW-1:0]         KeyMulA       = 32'd13;
  localparam logic [KeyW-1:0]         KeyMulB       = 32'd29;
  localparam logic [TunnelFieldW-1:0] TunMask       = TunnelFieldW'((64'd1 << TunW) - 1);
  localparam logic [CfgAddrW-1:0]     HashPrimeAddr = {RegHashPrime, 2'b00};

  localparam int NumPhases      = 7;
  localparam int RequestsPerSet = 200;
  localparam int HotBuckets     = 3;
  localparam int HotExtra       = 5;
  localparam int ColdKeys       = 16;
  localparam int IdlePct        = 32;
  localparam int QuietFrom      = 900;
  localparam int QuietTo        = 1100;
  localparam int HoldAfter      = 400;
  localparam int HoldCycles     = 300;
  localparam int SettleCycles   = 40;

  typedef struct packed {
    logic                   found;
    logic [TunnelFieldW-1:0] tunnel;
    status_e                status;
    logic [EntryCountW-1:0] entries;
    logic [OverrideW-1:0]   overrides;
  } flow_result_t;

  // Mirror of the flow table plus the queue of results still owed by the block
  class flow_table_mirror;
    logic [KeyW-1:0]         slot_key [NumSlots];
    logic [TunnelFieldW-1:0] slot_tunnel [NumSlots];
    bit                      slot_used [NumSlots];
    logic [EntryCountW-1:0]  live_count;
    logic [OverrideW-1:0]    update_count;
    logic [KeyW-1:0]         hash_prime;
    flow_result_t            owed_results [$];
    int unsigned             mismatches;
    int unsigned             outcome_tally [4];

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]   = 1'b0;
        slot_key[i]    = '0;
        slot_tunnel[i] = '0;
      end
      live_count   = '0;
      update_count = '0;
      hash_prime   = HashPrimeReset;
      mismatches   = 0;
      foreach (outcome_tally[i]) outcome_tally[i] = 0;
    endfunction

    // Scramble the key, reduce by the prime unless it is zero, keep the low bits
    function int unsigned bucket_of(logic [KeyW-1:0] ip);
      logic [KeyW-1:0] mixed;
      mixed = ip * KeyMulA * KeyMulB;
      if (hash_prime != '0) mixed = mixed % hash_prime;
      return int'(mixed[BucketBits-1:0]);
    endfunction

    // Apply one accepted request to the mirror and queue its result
    function void note_request(logic [1:0] cmd, logic [KeyW-1:0] ip,
                               logic [TunnelFieldW-1:0] tun);
      int           base;
      int           hit;
      int           spare;
      int           w;
      flow_result_t res;
      logic [TunnelFieldW-1:0] tval;
      base  = int'(bucket_of(ip)) * Ways;
      hit   = -1;
      spare = -1;
      tval  = tun & TunMask;
      for (w = 0; w < Ways; w++) begin
        if (slot_used[base + w]) begin
          if (hit < 0 && slot_key[base + w] == ip) hit = base + w;
        end else if (spare < 0) begin
          spare = base + w;
        end
      end
      res.found  = 1'b0;
      res.tunnel = '0;
      res.status = StMiss;
      case (cmd)
        CmdInsert: begin
          if (hit >= 0) begin
            slot_tunnel[hit] = tval;
            update_count++;
            res.found  = 1'b1;
            res.tunnel = tval;
            res.status = StHit;
          end else if (spare >= 0) begin
            slot_key[spare]    = ip;
            slot_tunnel[spare] = tval;
            slot_used[spare]   = 1'b1;
            live_count++;
            res.tunnel = tval;
            res.status = StInserted;
          end else begin
            res.status = StFull;
          end
        end
        CmdDelete: begin
          if (hit >= 0) begin
            res.found  = 1'b1;
            res.tunnel = slot_tunnel[hit];
            res.status = StHit;
            slot_used[hit] = 1'b0;
            live_count--;
          end
        end
        default: begin
          if (hit >= 0) begin
            res.found  = 1'b1;
            res.tunnel = slot_tunnel[hit];
            res.status = StHit;
          end
        end
      endcase
      res.entries   = live_count;
      res.overrides = update_count;
      outcome_tally[res.status]++;
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    // Compare one delivered result with the oldest owed one
    task check_result(logic found, logic [TunnelFieldW-1:0] tunnel, logic [1:0] status,
                      logic [EntryCountW-1:0] entries, logic [OverrideW-1:0] overrides);
      flow_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with none owed (status %0d)", status));
        return;
      end
      want = owed_results.pop_front();
      if (found !== want.found)
        report_mismatch($sformatf("found %b, want %b", found, want.found));
      if (tunnel !== want.tunnel)
        report_mismatch($sformatf("tunnel_out %h, want %h", tunnel, want.tunnel));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %s", status, want.status.name()));
      if (entries !== want.entries)
        report_mismatch($sformatf("entry_count %0d, want %0d", entries, want.entries));
      if (overrides !== want.overrides)
        report_mismatch($sformatf("override_count %0d, want %0d", overrides, want.overrides));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              command_i;
  logic [KeyW-1:0]         ip_addr_i;
  logic [TunnelFieldW-1:0] tunnel_ref_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    found_o;
  logic [TunnelFieldW-1:0] tunnel_out_o;
  logic [1:0]              status_o;
  logic [EntryCountW-1:0]  entry_count_o;
  logic [OverrideW-1:0]    override_count_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrW-1:0]     paddr;
  logic [CfgDataW-1:0]     pwdata;
  logic [CfgDataW-1:0]     prdata;
  logic                    pready;

  flow_table_mirror table_mirror = new();
  logic [KeyW-1:0]  key_pool [$];
  int unsigned      sent_total = 0;
  int unsigned      results_seen = 0;

  ip_keyed_hash_table u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .ip_addr_i        (ip_addr_i),
    .tunnel_ref_i     (tunnel_ref_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .tunnel_out_o     (tunnel_out_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .override_count_o (override_count_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold a request until accepted, with an occasional random gap ahead of it
  task automatic offer_request(input logic [1:0] cmd, input logic [KeyW-1:0] ip,
                               input logic [TunnelFieldW-1:0] tun);
    bit          taken;
    int unsigned gap;
    if (!(sent_total >= QuietFrom && sent_total < QuietTo) &&
        $urandom_range(99) < IdlePct) begin
      gap = $urandom_range(24, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    ip_addr_i    <= ip;
    tunnel_ref_i <= tun;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end
    table_mirror.note_request(cmd, ip, tun);
    sent_total++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (table_mirror.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // APB transfer: setup, access until pready, then release the bus
  task automatic apb_transfer(input bit is_write, input logic [CfgDataW-1:0] wdata,
                              output logic [CfgDataW-1:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= HashPrimeAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done  = (pready === 1'b1);
      rdata = prdata;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the prime, mirror it, and read it back
  task automatic set_hash_prime(input logic [KeyW-1:0] value);
    logic [CfgDataW-1:0] rdata;
    apb_transfer(1'b1, value, rdata);
    table_mirror.hash_prime = value;
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== value)
      table_mirror.report_mismatch($sformatf("hash_prime reads %h, want %h", rdata, value));
  endtask

  // Keys for one phase: a few groups that share a bucket, some loners, the extremes
  function automatic void build_key_pool();
    logic [KeyW-1:0] anchor;
    logic [KeyW-1:0] cand;
    int unsigned     target;
    int unsigned     matched;
    int unsigned     tries;
    key_pool.delete();
    repeat (HotBuckets) begin
      anchor = $urandom;
      target = table_mirror.bucket_of(anchor);
      key_pool.push_back(anchor);
      matched = 0;
      tries   = 0;
      while (matched < HotExtra && tries < 50000) begin
        cand = $urandom;
        tries++;
        if (table_mirror.bucket_of(cand) == target) begin
          key_pool.push_back(cand);
          matched++;
        end
      end
    end
    repeat (ColdKeys) key_pool.push_back($urandom);
    key_pool.push_back('0);
    key_pool.push_back('1);
  endfunction

  // Results: random stalls, a long hold that repeats until a result is taken, one stretch without stalls
  initial begin : result_sink
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (results_seen == HoldAfter) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (results_seen >= QuietFrom && results_seen < QuietTo)
        out_stall_i <= 1'b0;
      else
        out_stall_i <= ($urandom_range(99) < IdlePct);
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        table_mirror.check_result(found_o, tunnel_out_o, status_o, entry_count_o,
                                  override_count_o);
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0]         phase_primes [NumPhases];
    logic [CfgDataW-1:0]     rdata;
    logic [1:0]              cmd;
    logic [KeyW-1:0]         ip;
    int unsigned             pick;
    int                      p;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CmdInsert;
    ip_addr_i    <= '0;
    tunnel_ref_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    phase_primes = '{32'd65521, 32'd2, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd1021,
                     32'd0};
    phase_primes[NumPhases-1] = $urandom_range(32'hFFFF_FFFF, 2);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the reset value of the prime
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== HashPrimeReset)
      table_mirror.report_mismatch($sformatf("hash_prime after reset %h", rdata));

    for (p = 0; p < NumPhases; p++) begin
      drain_results();
      set_hash_prime(phase_primes[p]);
      build_key_pool();

      if (p == 0) begin
        // Extreme keys and tunnels, update, alias search, delete and miss
        offer_request(CmdInsert, 32'h0000_0000, 16'h0000);
        offer_request(CmdInsert, 32'hFFFF_FFFF, 16'hFFFF);
        offer_request(CmdSearch, 32'h0000_0000, 16'hFFFF);
        offer_request(CmdSearch, 32'hFFFF_FFFF, 16'h0000);
        offer_request(CmdInsert, 32'hFFFF_FFFF, 16'h5A5A);
        offer_request(CmdSearchAlias, 32'hFFFF_FFFF, 16'hA5A5);
        offer_request(CmdSearchAlias, 32'h1234_5678, 16'h0001);
        offer_request(CmdDelete, 32'h0000_0000, 16'h7FFF);
        offer_request(CmdDelete, 32'h0000_0000, 16'h0000);
        offer_request(CmdSearch, 32'h0000_0000, 16'h0000);
        // Fill one bucket, then push one more key into it
        offer_request(CmdInsert, key_pool[0], 16'hAAAA);
        offer_request(CmdInsert, key_pool[1], 16'h5555);
        offer_request(CmdInsert, key_pool[2], 16'h8000);
        offer_request(CmdInsert, key_pool[3], 16'h0001);
        offer_request(CmdInsert, key_pool[4], 16'h1357);
        offer_request(CmdSearch, key_pool[4], 16'h0000);
        offer_request(CmdDelete, key_pool[4], 16'h0000);
        // Free a middle slot and refill it with the refused key
        offer_request(CmdDelete, key_pool[1], 16'h0000);
        offer_request(CmdInsert, key_pool[4], 16'h2468);
        offer_request(CmdSearch, key_pool[3], 16'h0000);
        offer_request(CmdInsert, key_pool[5], 16'hFFFE);
        offer_request(CmdInsert, key_pool[2], 16'h8001);
        offer_request(CmdDelete, 32'hFFFF_FFFF, 16'h0000);
        offer_request(CmdSearch, key_pool[1], 16'h0000);
      end

      // Random traffic, mostly on the pool so hits, updates and full buckets occur
      repeat (RequestsPerSet) begin
        pick = $urandom_range(99);
        if (pick < 45)      cmd = CmdInsert;
        else if (pick < 70) cmd = CmdSearch;
        else if (pick < 95) cmd = CmdDelete;
        else                cmd = CmdSearchAlias;
        if ($urandom_range(99) < 85) ip = key_pool[$urandom_range(key_pool.size() - 1)];
        else ip = $urandom;
        offer_request(cmd, ip, TunnelFieldW'($urandom));
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("ran %0d requests under %0d hash primes, zero and all-ones among them",
             sent_total, NumPhases);
    $display("outcomes: %0d new, %0d hit or updated, %0d missed, %0d bucket full",
             table_mirror.outcome_tally[StInserted], table_mirror.outcome_tally[StHit],
             table_mirror.outcome_tally[StMiss], table_mirror.outcome_tally[StFull]);
    if (table_mirror.mismatches == 0 && table_mirror.owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ikh_pkg.sv
hw/rtl/ikh_ram.sv
hw/rtl/ikh_front.sv
hw/rtl/ikh_queue.sv
hw/rtl/ikh_back.sv
hw/rtl/ip_keyed_hash_table.sv
tb/ip_keyed_hash_table_tb.sv
